[hw/rtl/art_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_pkg: shared types and constants of the address reservation table
// Holds the word formats of both channels, the table entry format, the result
// codes and the sequencer states.
// ----------------------------------------------------------------------------
package art_pkg;

    // Table geometry and page size.
    localparam int MAX_ENTRIES = 16;
    localparam int PAGE_SHIFT  = 12;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 33;

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [35:0]       TOP_OF_SPACE = 36'h1_0000_0000;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

    // Result codes.
    localparam logic [2:0] RC_COVERED  = 3'd0;
    localparam logic [2:0] RC_MERGED   = 3'd1;
    localparam logic [2:0] RC_APPENDED = 3'd2;
    localparam logic [2:0] RC_WIDENED  = 3'd3;
    localparam logic [2:0] RC_DONE     = 3'd4;

    // Operation codes.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] start_addr;
        logic [LEN_W-1:0]  length;
    } req_word_t;

    typedef struct packed {
        logic [2:0]       result_code;
        logic [LEN_W-1:0] overlap_end;
    } rsp_word_t;

    // One reserved range as stored in the table.
    typedef struct packed {
        logic [ADDR_W-1:0] begin_addr;
        logic [LEN_W-1:0]  size;
    } entry_t;

    // Write request from the sequencer to the table.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    // Outcome of comparing the current item against one entry.
    typedef struct packed {
        logic             covered;
        logic             abut_after;
        logic             abut_before;
        logic             overlap;
        logic [33:0]      entry_end;
        logic [LEN_W-1:0] grown_size;
    } match_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_WALK,
        ST_EVAL,
        ST_WRITE,
        ST_HULL,
        ST_HULL_WR,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/art_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_table: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module art_table
    import art_pkg::*;
(
    input  wire logic             clk,
    input  wire tbl_wr_t          wr,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [MAX_ENTRIES];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[hw/rtl/art_match.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_match: shared compare unit
// Compares the current range against one table entry and forms the entry end
// and the grown size used by a merge.
// ----------------------------------------------------------------------------
module art_match
    import art_pkg::*;
(
    input  wire entry_t            entry,
    input  wire logic [ADDR_W-1:0] page_begin,
    input  wire logic [LEN_W-1:0]  page_end,
    input  wire logic [LEN_W-1:0]  page_size,
    input  wire logic [ADDR_W-1:0] query_begin,
    input  wire logic [33:0]       query_end,
    output match_t                 res
);

    logic [33:0] ee;

    // Entry end, one add.
    assign ee = 34'(entry.begin_addr) + 34'(entry.size);

    // Compares against the entry bounds.
    always_comb
    begin
        res.entry_end   = ee;
        res.covered     = (page_begin >= entry.begin_addr) && (34'(page_end) <= ee);
        res.abut_after  = (ee == 34'(page_begin));
        res.abut_before = (LEN_W'(entry.begin_addr) == page_end);
        res.overlap     = (34'(entry.begin_addr) < query_end) && (ee > 34'(query_begin));
        res.grown_size  = entry.size + page_size;
    end

endmodule
`default_nettype wire

[hw/rtl/art_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_seq: item sequencer
// Widens an add to whole pages, walks the table one entry at a time through
// the shared compare unit, then merges, appends, widens or answers a query.
// ----------------------------------------------------------------------------
module art_seq
    import art_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire req_word_t req_word,
    input  wire logic      rsp_ready,
    input  wire entry_t    rd_data,
    input  wire match_t    cmp,
    output logic           busy,
    output logic           done,
    output rsp_word_t      result,
    output logic [IDX_W-1:0] rd_addr,
    output tbl_wr_t        wr,
    output logic [ADDR_W-1:0] page_begin,
    output logic [LEN_W-1:0]  page_end,
    output logic [LEN_W-1:0]  page_size,
    output logic [ADDR_W-1:0] query_begin,
    output logic [33:0]       query_end
);

    state_t state_reg, state_next;

    logic              op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] b_reg, b_next;
    logic [34:0]       l_reg, l_next;
    logic [LEN_W-1:0]  e_reg, e_next;
    logic [33:0]       qe_reg, qe_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [2:0]        code_reg, code_next;
    logic [LEN_W-1:0]  ovl_reg, ovl_next;
    logic              append_reg, append_next;
    logic [IDX_W-1:0]  wr_addr_reg, wr_addr_next;
    entry_t            wr_data_reg, wr_data_next;
    logic [ADDR_W-1:0] nb_reg, nb_next;
    logic [33:0]       ne_reg, ne_next;

    logic        start;
    logic        walk_more;
    logic        table_full;
    logic [35:0] e_full;

    assign start      = req_valid && (state_reg == ST_IDLE);
    assign walk_more  = (idx_reg < count_reg);
    assign table_full = (count_reg == FULL_CNT);
    assign e_full     = 36'(b_reg) + 36'(l_reg);

    // Operands of the compare unit.
    assign page_begin  = b_reg;
    assign page_end    = e_reg;
    assign page_size   = l_reg[LEN_W-1:0];
    assign query_begin = addr_reg;
    assign query_end   = qe_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if ((op_reg == OP_ADD) && (e_full > TOP_OF_SPACE))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_more)
                begin
                    state_next = ST_EVAL;
                end
                else if (op_reg == OP_QUERY)
                begin
                    state_next = ST_RESP;
                end
                else if (!table_full)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_HULL;
                end
            end
            ST_EVAL:
            begin
                if (op_reg == OP_QUERY)
                begin
                    state_next = cmp.overlap ? ST_RESP : ST_WALK;
                end
                else if (cmp.covered)
                begin
                    state_next = ST_RESP;
                end
                else if (cmp.abut_after || cmp.abut_before)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_RESP;
            end
            ST_HULL:
            begin
                state_next = ST_HULL_WR;
            end
            ST_HULL_WR:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        busy    = (state_reg != ST_IDLE);
        done    = (state_reg == ST_RESP);
        result.result_code = code_reg;
        result.overlap_end = ovl_reg;
        rd_addr = idx_reg[IDX_W-1:0];
        wr.en   = 1'b0;
        wr.addr = wr_addr_reg;
        wr.data = wr_data_reg;
        unique case (state_reg)
            ST_WALK:
            begin
                // Past the last valid entry, fetch the last slot for widening.
                rd_addr = walk_more ? idx_reg[IDX_W-1:0] : LAST_IDX;
            end
            ST_WRITE:
            begin
                wr.en = 1'b1;
            end
            ST_HULL_WR:
            begin
                wr.en              = 1'b1;
                wr.addr            = LAST_IDX;
                wr.data.begin_addr = nb_reg;
                wr.data.size       = LEN_W'(ne_reg - 34'(nb_reg));
            end
            default:
            begin
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        op_next      = op_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        b_next       = b_reg;
        l_next       = l_reg;
        e_next       = e_reg;
        qe_next      = qe_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        code_next    = code_reg;
        ovl_next     = ovl_reg;
        append_next  = append_reg;
        wr_addr_next = wr_addr_reg;
        wr_data_next = wr_data_reg;
        nb_next      = nb_reg;
        ne_next      = ne_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = req_word.opcode;
                    addr_next = req_word.start_addr;
                    len_next  = req_word.length;
                end
            end
            ST_PREP:
            begin
                // Page-align the begin and round the length up to whole pages.
                b_next      = addr_reg & ~PAGE_MASK;
                l_next      = (35'(addr_reg & PAGE_MASK) + 35'(len_reg) + 35'(PAGE_MASK))
                              & ~35'(PAGE_MASK);
                qe_next     = 34'(addr_reg) + 34'(len_reg);
                ovl_next    = '0;
                code_next   = RC_DONE;
                append_next = 1'b0;
            end
            ST_CHECK:
            begin
                e_next   = e_full[LEN_W-1:0];
                idx_next = '0;
            end
            ST_WALK:
            begin
                if (!walk_more && (op_reg == OP_ADD) && !table_full)
                begin
                    wr_addr_next            = count_reg[IDX_W-1:0];
                    wr_data_next.begin_addr = b_reg;
                    wr_data_next.size       = l_reg[LEN_W-1:0];
                    append_next             = 1'b1;
                    code_next               = RC_APPENDED;
                end
            end
            ST_EVAL:
            begin
                if (op_reg == OP_QUERY)
                begin
                    if (cmp.overlap)
                    begin
                        ovl_next = cmp.entry_end[LEN_W-1:0];
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else if (cmp.covered)
                begin
                    code_next = RC_COVERED;
                end
                else if (cmp.abut_after)
                begin
                    wr_addr_next            = idx_reg[IDX_W-1:0];
                    wr_data_next.begin_addr = rd_data.begin_addr;
                    wr_data_next.size       = cmp.grown_size;
                    code_next               = RC_MERGED;
                end
                else if (cmp.abut_before)
                begin
                    wr_addr_next            = idx_reg[IDX_W-1:0];
                    wr_data_next.begin_addr = b_reg;
                    wr_data_next.size       = cmp.grown_size;
                    code_next               = RC_MERGED;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_WRITE:
            begin
                if (append_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_HULL:
            begin
                // Hull of the last entry and the new range.
                nb_next   = (b_reg < rd_data.begin_addr) ? b_reg : rd_data.begin_addr;
                ne_next   = (34'(e_reg) > cmp.entry_end) ? 34'(e_reg) : cmp.entry_end;
                code_next = RC_WIDENED;
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        len_reg     <= len_next;
        b_reg       <= b_next;
        l_reg       <= l_next;
        e_reg       <= e_next;
        qe_reg      <= qe_next;
        idx_reg     <= idx_next;
        code_reg    <= code_next;
        ovl_reg     <= ovl_next;
        append_reg  <= append_next;
        wr_addr_reg <= wr_addr_next;
        wr_data_reg <= wr_data_next;
        nb_reg      <= nb_next;
        ne_reg      <= ne_next;
    end

endmodule
`default_nettype wire

[hw/rtl/address_reservation_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// address_reservation_table_top: table of reserved 32-bit address ranges
// Adds page-aligned reservations with merging, and answers overlap queries.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_stall   req_word_t (opcode, start_addr, length)
//   rsp      out        rsp_valid/rsp_stall   rsp_word_t (result_code, overlap_end)
//
// One word is in flight at a time; req_stall is high from acceptance until
// its result has moved into the output register.
// An item's time grows with the number of entries visited: the walk reads each
// entry through the single read port of the table, then compares it.
// Reset empties the table at once by clearing the entry count.
// A stalled result stays in the output register while the next word is
// already being worked on.
// ----------------------------------------------------------------------------
module address_reservation_table_top
    import art_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req_word,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp_word
);

    logic              seq_busy;
    logic              seq_done;
    rsp_word_t         seq_result;
    logic              slot_free;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    tbl_wr_t           wr;
    match_t            cmp;
    logic [ADDR_W-1:0] page_begin;
    logic [LEN_W-1:0]  page_end;
    logic [LEN_W-1:0]  page_size;
    logic [ADDR_W-1:0] query_begin;
    logic [33:0]       query_end;

    logic      rsp_valid_reg, rsp_valid_next;
    rsp_word_t rsp_word_reg, rsp_word_next;

    assign req_stall = seq_busy;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    art_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    art_match u_match (
        .entry       (rd_data),
        .page_begin  (page_begin),
        .page_end    (page_end),
        .page_size   (page_size),
        .query_begin (query_begin),
        .query_end   (query_end),
        .res         (cmp)
    );

    art_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_word    (req_word),
        .rsp_ready   (slot_free),
        .rd_data     (rd_data),
        .cmp         (cmp),
        .busy        (seq_busy),
        .done        (seq_done),
        .result      (seq_result),
        .rd_addr     (rd_addr),
        .wr          (wr),
        .page_begin  (page_begin),
        .page_end    (page_end),
        .page_size   (page_size),
        .query_begin (query_begin),
        .query_end   (query_end)
    );

    // Output register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (slot_free)
        begin
            rsp_valid_next = seq_done;
            if (seq_done)
            begin
                rsp_word_next = seq_result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // An accepted word always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("accepted word did not make the block busy");

    // A finished result is only offered while the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> seq_busy)
        else $error("result offered while idle");

    // Result codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.result_code <= RC_DONE))
        else $error("undefined result code");

    // Only a query or a rejected add may report an overlap end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_word.result_code != RC_DONE)) |-> (rsp_word.overlap_end == '0))
        else $error("add result carries an overlap end");

endmodule
`default_nettype wire

[dv/address_reservation_table_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_reservation_table_top_tb: self-checking bench of the reservation table
// Drives add and query words with random gaps and takes the results back with
// random stalls. A mirror of the table computes each result at acceptance, and
// every result word is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module address_reservation_table_top_tb;
    import art_pkg::*;

    localparam logic [31:0] PAGE_BYTES   = 32'd1 << PAGE_SHIFT;
    localparam int          DRAIN_CYCLES = 2 * MAX_ENTRIES + 10;
    localparam int          RANDOM_WORDS = 600;

    // Mirror of the reserved ranges, and the results still owed by the block.
    class reservation_checker;
        logic [ADDR_W-1:0] range_begin [MAX_ENTRIES];
        logic [LEN_W-1:0]  range_size  [MAX_ENTRIES];
        int unsigned       range_count;
        rsp_word_t         awaited_results [$];
        int unsigned       failures;

        function new();
            range_count = 0;
            failures    = 0;
        endfunction

        // Page-widens an add: reject, cover, merge, append or widen the last range.
        function logic [2:0] reserve_range(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
            logic [35:0] page_mask;
            logic [35:0] lo;
            logic [35:0] span;
            logic [35:0] hi;
            logic [35:0] eb;
            logic [35:0] ee;
            logic [35:0] nb;
            logic [35:0] ne;
            int unsigned i;
            int unsigned last;
            page_mask = {4'b0, PAGE_MASK};
            lo        = {4'b0, addr} & ~page_mask;
            span      = ({4'b0, addr} - lo + {3'b0, len} + page_mask) & ~page_mask;
            hi        = lo + span;
            if (hi > TOP_OF_SPACE)
                return RC_DONE;
            for (i = 0; i < range_count; i++)
            begin
                eb = {4'b0, range_begin[i]};
                ee = eb + {3'b0, range_size[i]};
                if (lo >= eb && hi <= ee)
                    return RC_COVERED;
                if (ee == lo)
                begin
                    range_size[i] = range_size[i] + span[LEN_W-1:0];
                    return RC_MERGED;
                end
                if (eb == hi)
                begin
                    range_begin[i] = lo[ADDR_W-1:0];
                    range_size[i]  = range_size[i] + span[LEN_W-1:0];
                    return RC_MERGED;
                end
            end
            if (range_count < MAX_ENTRIES)
            begin
                range_begin[range_count] = lo[ADDR_W-1:0];
                range_size[range_count]  = span[LEN_W-1:0];
                range_count++;
                return RC_APPENDED;
            end
            // The table is full: the last range grows to the hull of both.
            last = MAX_ENTRIES - 1;
            nb   = {4'b0, range_begin[last]};
            ne   = nb + {3'b0, range_size[last]};
            if (lo < nb)
                nb = lo;
            if (hi > ne)
                ne = hi;
            range_begin[last] = nb[ADDR_W-1:0];
            range_size[last]  = LEN_W'(ne - nb);
            return RC_WIDENED;
        endfunction

        // End of the first range that overlaps the query, or zero.
        function logic [LEN_W-1:0] find_overlap(logic [ADDR_W-1:0] addr,
                                                logic [LEN_W-1:0] len);
            logic [35:0] qe;
            logic [35:0] ee;
            int unsigned i;
            qe = {4'b0, addr} + {3'b0, len};
            for (i = 0; i < range_count; i++)
            begin
                ee = {4'b0, range_begin[i]} + {3'b0, range_size[i]};
                if ({4'b0, range_begin[i]} < qe && ee > {4'b0, addr})
                    return ee[LEN_W-1:0];
            end
            return '0;
        endfunction

        function void note_request(req_word_t w);
            rsp_word_t res;
            if (w.opcode == OP_ADD)
            begin
                res.result_code = reserve_range(w.start_addr, w.length);
                res.overlap_end = '0;
            end
            else
            begin
                res.result_code = RC_DONE;
                res.overlap_end = find_overlap(w.start_addr, w.length);
            end
            awaited_results.push_back(res);
        endfunction

        function void check_result(rsp_word_t got);
            rsp_word_t want;
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result word: result_code %0d overlap_end 0x%0h",
                       got.result_code, got.overlap_end);
                failures++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.result_code !== want.result_code)
            begin
                $error("result_code: expected %0d, actual %0d",
                       want.result_code, got.result_code);
                failures++;
            end
            if (got.overlap_end !== want.overlap_end)
            begin
                $error("overlap_end: expected 0x%0h, actual 0x%0h",
                       want.overlap_end, got.overlap_end);
                failures++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req_word;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp_word;

    reservation_checker sb = new();

    int req_phase_left = 0;
    bit req_phase_quiet = 1'b0;
    int rsp_phase_left = 0;
    bit rsp_phase_quiet = 1'b0;

    address_reservation_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Idle cycles per word; each run of words is drawn as busy or quiet.
    function automatic int draw_wait(ref int phase_left, ref bit phase_quiet);
        if (phase_left == 0)
        begin
            phase_left  = $urandom_range(10, 40);
            phase_quiet = ($urandom_range(0, 3) == 0);
        end
        phase_left--;
        return phase_quiet ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic req_word_t make_word(logic op, logic [ADDR_W-1:0] addr,
                                            logic [LEN_W-1:0] len);
        req_word_t w;
        w.opcode     = op;
        w.start_addr = addr;
        w.length     = len;
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return {1'b1, 32'h0};
            2: return {1'b0, $urandom};
            default: return LEN_W'($urandom_range(1, 32'h8000));
        endcase
    endfunction

    // Random word, mostly aimed at the edges and insides of stored ranges.
    function automatic req_word_t random_request();
        req_word_t   w;
        int unsigned pick;
        int unsigned k;
        logic [35:0] lo;
        logic [35:0] hi;
        logic [35:0] span;
        logic [31:0] pages;
        pick  = $urandom_range(0, 99);
        pages = 32'($urandom_range(1, 8)) << PAGE_SHIFT;
        lo    = '0;
        hi    = '0;
        if (sb.range_count > 0)
        begin
            k  = $urandom_range(0, sb.range_count - 1);
            lo = {4'b0, sb.range_begin[k]};
            hi = lo + {3'b0, sb.range_size[k]};
        end
        w = make_word(OP_ADD, $urandom, random_length());
        if (pick < 35)
        begin
            w.opcode = OP_QUERY;
            if (pick < 20)
            begin
                w.start_addr = lo[31:0] + $urandom_range(0, 32'h3000) - 32'h1000;
                w.length     = LEN_W'($urandom_range(0, 32'h3000));
            end
        end
        else if (pick < 50)
        begin
            // Starts in the page where a range ends.
            w.start_addr = hi[31:0] + $urandom_range(0, PAGE_BYTES - 1);
            w.length     = LEN_W'($urandom_range(0, 32'h6000));
        end
        else if (pick < 63)
        begin
            // Ends on the page where a range begins.
            w.start_addr = lo[31:0] - pages;
            w.length     = LEN_W'(pages - $urandom_range(0, PAGE_BYTES - 1));
        end
        else if (pick < 73)
        begin
            span         = hi - lo;
            w.start_addr = lo[31:0] + ((span != 0) ? 32'({4'b0, $urandom} % span) : 32'd0);
            w.length     = LEN_W'($urandom_range(0, 32'h2000));
        end
        else if (pick < 80)
        begin
            w.start_addr = $urandom | 32'hF000_0000;
            w.length     = ($urandom_range(0, 3) == 0) ? {1'b1, 32'h0}
                                                       : {1'b0, $urandom | 32'h1000_0000};
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                w.start_addr = w.start_addr & ~(PAGE_BYTES - 1);
            if ($urandom_range(0, 1) == 0)
                w.length = LEN_W'($urandom_range(0, 32'h10000));
        end
        return w;
    endfunction

    // Presents one word after its gap and holds it until the block takes it.
    task automatic send_request(input req_word_t w);
        int gap;
        gap = draw_wait(req_phase_left, req_phase_quiet);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(w);
    endtask

    task automatic run_directed();
        int k;
        // Empty table, then the basic add outcomes on the first range.
        send_request(make_word(OP_QUERY, 32'h0, 33'h0));
        send_request(make_word(OP_ADD, 32'h0000_1000, 33'h1000));
        send_request(make_word(OP_ADD, 32'h0000_1000, 33'h0));
        send_request(make_word(OP_ADD, 32'h0000_2000, 33'h1000));
        send_request(make_word(OP_ADD, 32'h0000_0000, 33'h1000));
        send_request(make_word(OP_ADD, 32'h0000_1234, 33'h10));
        // Top of the address space: exactly reaching 4 GiB, and just past it.
        send_request(make_word(OP_ADD, 32'hFFFF_F000, 33'h1000));
        send_request(make_word(OP_ADD, 32'hFFFF_FFFF, 33'h1));
        send_request(make_word(OP_ADD, 32'hFFFF_FFFF, 33'h2));
        send_request(make_word(OP_ADD, 32'h0000_1000, 33'h1_0000_0000));
        // An aligned empty add becomes a range of length zero.
        send_request(make_word(OP_ADD, 32'h5000_0000, 33'h0));
        send_request(make_word(OP_QUERY, 32'h0, 33'h1_0000_0000));
        send_request(make_word(OP_QUERY, 32'hFFFF_FFFF, 33'h1));
        send_request(make_word(OP_QUERY, 32'h0000_1000, 33'h0));
        send_request(make_word(OP_QUERY, 32'h0000_3000, 33'h1000));
        // Fill the table, then widen the last range upward and downward.
        for (k = 0; k < MAX_ENTRIES - 3; k++)
            send_request(make_word(OP_ADD, 32'h1000_0000 + k * 32'h0100_0000, 33'h1800));
        send_request(make_word(OP_ADD, 32'h8000_0000, 33'h10));
        send_request(make_word(OP_ADD, 32'h0800_0000, 33'h1000));
    endtask

    // Result side: stalls for a drawn number of cycles, then takes one word.
    initial
    begin
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int n;
            n = draw_wait(rsp_phase_left, rsp_phase_quiet);
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            sb.check_result(rsp_word);
        end
    end

    // Main sequence: reset, directed words, random words, whole-space words, drain.
    initial
    begin
        int i;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_word  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (i = 0; i < RANDOM_WORDS; i++)
            send_request(random_request());
        // The whole space last, since it swallows every later add.
        send_request(make_word(OP_ADD, 32'h0, 33'h1_0000_0000));
        send_request(make_word(OP_QUERY, 32'h0, 33'h1_0000_0000));
        send_request(make_word(OP_QUERY, 32'h8000_0000, 33'h0));
        req_valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("[address_reservation_table_top] OK");
        else
            $display("[address_reservation_table_top] ERROR");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("[address_reservation_table_top] ERROR");
        $finish;
    end

endmodule
